/* rtl/size_class_page_allocator_defines.svh */
// Assertion macros used by the checker file of the allocator.
`ifndef SIZE_CLASS_PAGE_ALLOCATOR_DEFINES_SVH
`define SIZE_CLASS_PAGE_ALLOCATOR_DEFINES_SVH

// Checks a property at every rising clock edge outside reset.
`define SCPA_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checks a property at every rising clock edge, reset included.
`define SCPA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/scpa_pkg.sv */
// Types, constants and the block-limit table of the size-class page allocator.
package scpa_pkg;

    localparam int POOL_PAGES   = 64;
    localparam int PAGE_BYTES   = 1024;
    localparam int SIZE_CLASSES = 125;
    localparam int HDR_BYTES    = 24;
    localparam int STEP_BYTES   = 8;
    localparam int USABLE_BYTES = PAGE_BYTES - HDR_BYTES;

    localparam int PAGE_W  = 6;
    localparam int OFF_W   = 10;
    localparam int CLS_W   = 7;
    localparam int CNT_W   = 7;
    localparam int SLOT_W  = PAGE_W + OFF_W - 3;
    localparam int CLS_DEPTH = 2 ** CLS_W;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_PAGE  = 2'd1;
    localparam logic [1:0] ST_TOO_BIG  = 2'd2;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef struct packed {
        logic [CLS_W-1:0]  cls;
        logic [CNT_W-1:0]  used;
        logic [OFF_W:0]    carve;
        logic [OFF_W-1:0]  free_head;
        logic [CLS_W-1:0]  next;
    } t_page;

    typedef logic [CNT_W-1:0] t_limit_table [SIZE_CLASSES];

    function automatic t_limit_table build_limits();
        t_limit_table tbl;
        int           rem;
        int           quo;
        int           blk;
        for (int c = 0; c < SIZE_CLASSES; c++) begin
            blk = (c + 1) * STEP_BYTES;
            rem = USABLE_BYTES;
            quo = 0;
            for (int k = 0; k < USABLE_BYTES; k++) begin
                if (rem >= blk) begin
                    rem = rem - blk;
                    quo = quo + 1;
                end
            end
            tbl[c] = CNT_W'(quo);
        end
        return tbl;
    endfunction

    localparam t_limit_table BLOCK_LIMIT = build_limits();

endpackage

/* rtl/size_class_page_allocator.sv */
// Top level: request sequencer of the size-class page allocator over page and link RAMs.
// An allocate passes S_CLS, S_PG and S_LNK where needed, then S_ALC, set by the chain
// of dependent reads through the class table, page table and link RAM; if the pool is
// exhausted it stops in S_CLS, if too large in idle. An ignored free stops in S_FPG.
// One request is in flight at a time; a new beat is taken once the result is taken.
// Synchronous active-low reset empties all classes and the pool.
module size_class_page_allocator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,  // operation, request_size, block_address
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata   // granted_address, status
);
    import scpa_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CLS  = 3'd1;
    localparam logic [2:0] S_PG   = 3'd2;
    localparam logic [2:0] S_LNK  = 3'd3;
    localparam logic [2:0] S_ALC  = 3'd4;
    localparam logic [2:0] S_FPG  = 3'd5;
    localparam logic [2:0] S_FCLS = 3'd6;

    logic [2:0]        r_state, n_state;
    logic [CLS_W-1:0]  r_cls, n_cls;
    logic [PAGE_W-1:0] r_page, n_page;
    logic [OFF_W-1:0]  r_off, n_off;
    logic              r_fresh, n_fresh;
    t_page             r_pg, n_pg;
    logic [CLS_W-1:0]  r_taken, n_taken;
    logic              r_ov, n_ov;
    logic [15:0]       r_addr, n_addr;
    logic [1:0]        r_stat, n_stat;

    logic              in_op;
    logic [9:0]        in_size;
    logic [15:0]       in_baddr;
    logic              acc;

    logic              cls_we;
    logic [CLS_W-1:0]  cls_waddr, cls_wdata, cls_raddr, cls_q;
    logic              pg_we;
    logic [PAGE_W-1:0] pg_waddr, pg_raddr;
    t_page             pg_wdata, pg_q;
    logic              lnk_we;
    logic [SLOT_W-1:0] lnk_waddr, lnk_raddr;
    logic [OFF_W-1:0]  lnk_wdata, lnk_q;

    logic [OFF_W:0]    blk;
    logic [CNT_W-1:0]  used_inc;
    logic [OFF_W:0]    carve_dec;
    logic [CLS_W-1:0]  in_cls;
    logic [OFF_W:0]    in_blk;

    assign in_op    = i_s_axis_tdata[0];
    assign in_size  = i_s_axis_tdata[10:1];
    assign in_baddr = i_s_axis_tdata[26:11];
    assign in_cls   = in_size[9:3];
    assign in_blk   = ({4'b0, in_cls} + 11'd1) << 3;

    assign o_s_axis_tready = (r_state == S_IDLE) && !r_ov;
    assign acc             = i_s_axis_tvalid && o_s_axis_tready;
    assign o_m_axis_tvalid = r_ov;
    assign o_m_axis_tdata  = {6'b0, r_stat, r_addr};

    assign blk       = ({4'b0, r_pg.cls} + 11'd1) << 3;
    assign used_inc  = r_pg.used + CNT_W'(1);
    assign carve_dec = r_pg.carve - blk;

    always_comb begin
        cls_raddr = r_cls;
        pg_raddr  = r_page;
        case (r_state)
            S_IDLE:  cls_raddr = in_cls;
            S_FPG:   cls_raddr = pg_q.cls;
            default: cls_raddr = r_cls;
        endcase
        case (r_state)
            S_IDLE:  pg_raddr = in_baddr[15:10];
            S_CLS:   pg_raddr = PAGE_W'(cls_q - CLS_W'(1));
            default: pg_raddr = r_page;
        endcase
    end
    assign lnk_raddr = {r_page, r_pg.free_head[OFF_W-1:3]};

    always_comb begin
        n_state   = r_state;
        n_cls     = r_cls;
        n_page    = r_page;
        n_off     = r_off;
        n_fresh   = r_fresh;
        n_pg      = r_pg;
        n_taken   = r_taken;
        n_ov      = r_ov && !i_m_axis_tready;
        n_addr    = r_addr;
        n_stat    = r_stat;
        cls_we    = 1'b0;
        cls_waddr = r_cls;
        cls_wdata = '0;
        pg_we     = 1'b0;
        pg_waddr  = r_page;
        pg_wdata  = r_pg;
        lnk_we    = 1'b0;
        lnk_waddr = {r_page, r_off[OFF_W-1:3]};
        lnk_wdata = r_pg.free_head;
        case (r_state)
            S_IDLE: begin
                if (acc) begin
                    n_cls  = in_cls;
                    n_page = in_baddr[15:10];
                    n_off  = in_baddr[9:0];
                    if (in_op == OP_FREE) begin
                        n_state = S_FPG;
                    end else if (in_cls >= CLS_W'(SIZE_CLASSES)
                                 || in_blk > 11'(USABLE_BYTES)) begin
                        n_ov   = 1'b1;
                        n_addr = '0;
                        n_stat = ST_TOO_BIG;
                    end else begin
                        n_state = S_CLS;
                    end
                end
            end
            S_CLS: begin
                if (cls_q == '0) begin
                    if (r_taken >= CLS_W'(POOL_PAGES)) begin
                        n_state = S_IDLE;
                        n_ov    = 1'b1;
                        n_addr  = '0;
                        n_stat  = ST_NO_PAGE;
                    end else begin
                        n_page  = r_taken[PAGE_W-1:0];
                        n_fresh = 1'b1;
                        n_pg    = '{cls: r_cls, used: '0, carve: 11'(PAGE_BYTES),
                                    free_head: '0, next: '0};
                        n_state = S_ALC;
                    end
                end else begin
                    n_page  = PAGE_W'(cls_q - CLS_W'(1));
                    n_fresh = 1'b0;
                    n_state = S_PG;
                end
            end
            S_PG: begin
                n_pg    = pg_q;
                n_state = (pg_q.free_head != '0) ? S_LNK : S_ALC;
            end
            S_LNK: begin
                n_state = S_ALC;
            end
            S_ALC: begin
                pg_we         = 1'b1;
                pg_wdata      = r_pg;
                pg_wdata.used = used_inc;
                if (r_pg.free_head != '0) begin
                    n_off              = r_pg.free_head;
                    pg_wdata.free_head = lnk_q;
                end else begin
                    n_off          = carve_dec[OFF_W-1:0];
                    pg_wdata.carve = carve_dec;
                end
                cls_we    = 1'b1;
                cls_waddr = r_cls;
                cls_wdata = (used_inc >= BLOCK_LIMIT[r_cls]) ? r_pg.next
                                                             : {1'b0, r_page} + CLS_W'(1);
                if (r_fresh) begin
                    n_taken = r_taken + CLS_W'(1);
                end
                n_addr  = {r_page, n_off};
                n_stat  = ST_OK;
                n_ov    = 1'b1;
                n_state = S_IDLE;
            end
            S_FPG: begin
                n_pg  = pg_q;
                n_cls = pg_q.cls;
                if ({1'b0, r_page} >= r_taken || r_off < OFF_W'(HDR_BYTES)
                    || pg_q.used == '0) begin
                    n_ov    = 1'b1;
                    n_addr  = '0;
                    n_stat  = ST_OK;
                    n_state = S_IDLE;
                end else begin
                    n_state = S_FCLS;
                end
            end
            S_FCLS: begin
                pg_we              = 1'b1;
                pg_wdata           = r_pg;
                pg_wdata.used      = r_pg.used - CNT_W'(1);
                pg_wdata.free_head = r_off;
                if (r_pg.used == BLOCK_LIMIT[r_cls]) begin
                    pg_wdata.next = cls_q;
                    cls_we        = 1'b1;
                    cls_waddr     = r_cls;
                    cls_wdata     = {1'b0, r_page} + CLS_W'(1);
                end
                lnk_we  = 1'b1;
                n_ov    = 1'b1;
                n_addr  = '0;
                n_stat  = ST_OK;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_taken <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_taken <= n_taken;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cls   <= n_cls;
        r_page  <= n_page;
        r_off   <= n_off;
        r_fresh <= n_fresh;
        r_pg    <= n_pg;
        r_addr  <= n_addr;
        r_stat  <= n_stat;
    end

    scpa_class_mem u_class (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (cls_we),
        .i_waddr (cls_waddr),
        .i_wdata (cls_wdata),
        .i_raddr (cls_raddr),
        .o_rdata (cls_q)
    );

    scpa_ram #(.WIDTH($bits(t_page)), .DEPTH(POOL_PAGES)) u_page (
        .i_clk   (i_clk),
        .i_we    (pg_we),
        .i_waddr (pg_waddr),
        .i_wdata (pg_wdata),
        .i_raddr (pg_raddr),
        .o_rdata (pg_q)
    );

    scpa_ram #(.WIDTH(OFF_W), .DEPTH(2 ** SLOT_W)) u_link (
        .i_clk   (i_clk),
        .i_we    (lnk_we),
        .i_waddr (lnk_waddr),
        .i_wdata (lnk_wdata),
        .i_raddr (lnk_raddr),
        .o_rdata (lnk_q)
    );
endmodule

/* rtl/scpa_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
module scpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

/* rtl/scpa_class_mem.sv */
// Class head table: a RAM with per-entry valid bits so that reset empties every class.
module scpa_class_mem (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_we,
    input  logic [scpa_pkg::CLS_W-1:0] i_waddr,
    input  logic [scpa_pkg::CLS_W-1:0] i_wdata,
    input  logic [scpa_pkg::CLS_W-1:0] i_raddr,
    output logic [scpa_pkg::CLS_W-1:0] o_rdata
);
    import scpa_pkg::*;

    logic [CLS_W-1:0] mem [CLS_DEPTH];
    logic [CLS_DEPTH-1:0] r_valid;
    logic [CLS_W-1:0] r_q;
    logic             r_qv;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_q <= mem[i_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_qv    <= 1'b0;
        end else begin
            r_qv <= r_valid[i_raddr];
            if (i_we) begin
                r_valid[i_waddr] <= 1'b1;
            end
        end
    end

    assign o_rdata = r_qv ? r_q : '0;
endmodule

/* rtl/scpa_checker.sv */
// Port-level checker of the allocator and its bind to the top level.
`include "size_class_page_allocator_defines.svh"

module scpa_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_s_axis_tready,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [23:0] o_m_axis_tdata
);
    import scpa_pkg::*;

    logic        res_valid;
    logic        res_stall;
    logic [1:0]  res_status;
    logic [17:0] res_data;
    logic        stat_legal;
    logic        err_clean;

    assign res_valid  = o_m_axis_tvalid;
    assign res_stall  = o_m_axis_tvalid && !i_m_axis_tready;
    assign res_status = o_m_axis_tdata[17:16];
    assign res_data   = o_m_axis_tdata[17:0];
    assign stat_legal = (res_status <= ST_TOO_BIG);
    assign err_clean  = (res_status == ST_OK) || (o_m_axis_tdata[15:0] == 16'd0);

    `SCPA_ASSERT(a_status_range, i_clk, i_rst_n, res_valid |-> stat_legal, "bad status code")
    `SCPA_ASSERT(a_error_no_addr, i_clk, i_rst_n, res_valid |-> err_clean, "error with address")
    `SCPA_ASSERT(a_one_in_flight, i_clk, i_rst_n, res_valid |-> !o_s_axis_tready, "ready with result")
    `SCPA_ASSERT(a_hold, i_clk, i_rst_n, res_stall |=> res_valid && $stable(res_data), "stall broken")
    `SCPA_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> !res_valid, "result valid after reset")
endmodule

bind size_class_page_allocator scpa_checker u_scpa_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);
